@@ sv/linear_probe_hash_table_top_assert.svh @@
// assertion macros for the hash table
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");
`else
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/lpht_pkg.sv @@
package lpht_pkg;
    localparam int TableDepth = 256;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = IdxW + 1;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_LOOKUP   = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] key_hash;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] result_value;
        logic [7:0]  probes;
    } t_rsp;

    // one table entry as stored in memory
    typedef struct packed {
        logic [31:0]     key;
        logic [31:0]     value;
        logic [IdxW-1:0] home;
    } t_entry;

    // sequencer to memory
    typedef struct packed {
        logic            rd_en;
        logic [IdxW-1:0] rd_addr;
        logic            wr_en;
        logic [IdxW-1:0] wr_addr;
        t_entry          wr_data;
        logic            set_valid;
        logic            clr_valid;
        logic [IdxW-1:0] clr_addr;
    } t_mem_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_CHK,
        S_DEL_RD,
        S_DEL_CHK,
        S_HOME,
        S_RE_RD,
        S_RE_CHK,
        S_DONE
    } t_state;
endpackage

@@ sv/lpht_mod.sv @@
// iterative remainder: one quotient bit per cycle
module lpht_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_dividend,
    input  logic [lpht_pkg::CntW-1:0]     i_divisor,
    output logic                          o_done,
    output logic [lpht_pkg::CntW-1:0]     o_rem
);
    import lpht_pkg::*;

    logic [31:0]     r_dvd, n_dvd;
    logic [CntW:0]   r_rem, n_rem;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CntW+1:0] w_trial;

    // shift in one bit, subtract if it fits
    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_dvd[31]};
        if (i_start) begin
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[30:0], 1'b0};
            if (w_trial >= {2'b00, i_divisor}) begin
                n_rem = (CntW+1)'(w_trial - {2'b00, i_divisor});
            end else begin
                n_rem = w_trial[CntW:0];
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[CntW-1:0];
endmodule

@@ sv/lpht_mem.sv @@
// entry memory plus valid bits
module lpht_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpht_pkg::t_mem_cmd            i_cmd,
    output lpht_pkg::t_entry              o_rd_data,
    output logic                          o_rd_valid
);
    import lpht_pkg::*;

    t_entry                r_mem [TableDepth];
    logic [TableDepth-1:0] r_valid;

    // synchronous read and write
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            o_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    // valid bits, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                o_rd_valid <= r_valid[i_cmd.rd_addr];
            end
            if (i_cmd.clr_valid) begin
                r_valid[i_cmd.clr_addr] <= 1'b0;
            end
            if (i_cmd.set_valid) begin
                r_valid[i_cmd.wr_addr] <= 1'b1;
            end
        end
    end
endmodule

@@ sv/lpht_ctrl.sv @@
// probe sequencer
module lpht_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  lpht_pkg::t_req                i_req,
    input  logic [8:0]                    i_slots,
    output logic                          o_busy,
    output logic                          o_mod_start,
    output logic [31:0]                   o_mod_dividend,
    output logic [lpht_pkg::CntW-1:0]     o_n,
    input  logic                          i_mod_done,
    input  logic [lpht_pkg::CntW-1:0]     i_mod_rem,
    output lpht_pkg::t_mem_cmd            o_cmd,
    input  lpht_pkg::t_entry              i_rd_data,
    input  logic                          i_rd_valid,
    output logic                          o_strobe,
    output lpht_pkg::t_rsp                o_rsp
);
    import lpht_pkg::*;

    `include "linear_probe_hash_table_top_assert.svh"

    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic [CntW-1:0] r_n, n_n;
    logic [IdxW-1:0] r_home, n_home;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [CntW-1:0] r_i, n_i;
    logic [IdxW-1:0] r_hole, n_hole;
    logic [CntW-1:0] r_j, n_j;
    t_entry          r_ent, n_ent;
    logic [CntW-1:0] r_k, n_k;
    logic [IdxW-1:0] r_ri, n_ri;
    t_rsp            r_rsp, n_rsp;
    logic            r_strobe, n_strobe;
    logic [CntW-1:0] w_n;
    logic [CntW-1:0] w_inc;
    logic [CntW-1:0] w_hole_inc;
    logic [CntW-1:0] w_ri_inc;
    logic            w_home_far;
    t_mem_cmd        w_cmd;

    // clamp slot count to 1..TableDepth
    always_comb begin
        if (i_slots == 9'd0) begin
            w_n = CntW'(1);
        end else if ({23'd0, i_slots} > TableDepth) begin
            w_n = CntW'(TableDepth);
        end else begin
            w_n = CntW'(i_slots);
        end
    end

    // wrapping increments
    assign w_inc      = ({1'b0, r_idx} + 1'b1 == r_n) ? '0 : {1'b0, r_idx} + 1'b1;
    assign w_hole_inc = ({1'b0, r_hole} + 1'b1 == r_n) ? '0 : {1'b0, r_hole} + 1'b1;
    assign w_ri_inc   = ({1'b0, r_ri} + 1'b1 == r_n) ? '0 : {1'b0, r_ri} + 1'b1;

    // stored home lies beyond the current slot count
    assign w_home_far = {1'b0, i_rd_data.home} >= r_n;

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_n      = r_n;
        n_home   = r_home;
        n_idx    = r_idx;
        n_i      = r_i;
        n_hole   = r_hole;
        n_j      = r_j;
        n_ent    = r_ent;
        n_k      = r_k;
        n_ri     = r_ri;
        n_rsp    = r_rsp;
        n_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_n     = w_n;
                    n_i     = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_mod_done) begin
                    n_home = i_mod_rem[IdxW-1:0];
                    n_idx  = i_mod_rem[IdxW-1:0];
                    n_i    = '0;
                    n_rsp  = '{status: ST_NOT_FOUND, result_value: '0, probes: '0};
                    if (r_req.operation == OP_INSERT || r_req.operation == OP_LOOKUP
                        || r_req.operation == OP_DELETE) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (!i_rd_valid || i_rd_data.key == r_req.key) begin
                    if (r_req.operation == OP_INSERT) begin
                        n_rsp.status = i_rd_valid ? ST_UPDATED : ST_INSERTED;
                        n_rsp.probes = (r_i > CntW'(255)) ? 8'd255 : r_i[7:0];
                        n_state = S_DONE;
                    end else if (!i_rd_valid) begin
                        n_state = S_DONE;
                    end else if (r_req.operation == OP_LOOKUP) begin
                        n_rsp.status       = ST_FOUND;
                        n_rsp.result_value = i_rd_data.value;
                        n_state = S_DONE;
                    end else begin
                        n_rsp.status       = ST_DELETED;
                        n_rsp.result_value = i_rd_data.value;
                        n_hole = r_idx;
                        n_j    = CntW'(1);
                        n_state = S_DEL_RD;
                    end
                end else if (r_i + 1'b1 == r_n) begin
                    if (r_req.operation == OP_INSERT) begin
                        n_rsp.status = ST_FULL;
                    end
                    n_state = S_DONE;
                end else begin
                    n_i   = r_i + 1'b1;
                    n_idx = w_inc[IdxW-1:0];
                    n_state = S_RD;
                end
            end
            // walk the cluster after the freed slot
            S_DEL_RD: begin
                if (r_j >= r_n) begin
                    n_state = S_DONE;
                end else begin
                    n_hole  = w_hole_inc[IdxW-1:0];
                    n_state = S_DEL_CHK;
                end
            end
            S_DEL_CHK: begin
                if (!i_rd_valid) begin
                    n_state = S_DONE;
                end else begin
                    n_ent = i_rd_data;
                    n_ri  = i_rd_data.home;
                    n_k   = '0;
                    if (w_home_far) begin
                        n_state = S_HOME;
                    end else begin
                        n_state = S_RE_RD;
                    end
                end
            end
            // reduce the stored home modulo the current slot count
            S_HOME: begin
                if (i_mod_done) begin
                    n_ent.home = i_mod_rem[IdxW-1:0];
                    n_ri       = i_mod_rem[IdxW-1:0];
                    n_state    = S_RE_RD;
                end
            end
            S_RE_RD: n_state = S_RE_CHK;
            S_RE_CHK: begin
                if (!i_rd_valid || i_rd_data.key == r_ent.key || r_k + 1'b1 == r_n) begin
                    n_j     = r_j + 1'b1;
                    n_state = S_DEL_RD;
                end else begin
                    n_k  = r_k + 1'b1;
                    n_ri = w_ri_inc[IdxW-1:0];
                    n_state = S_RE_RD;
                end
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory commands
    always_comb begin
        w_cmd = '0;
        case (r_state)
            S_RD: begin
                w_cmd.rd_en   = 1'b1;
                w_cmd.rd_addr = r_idx;
            end
            S_CHK: begin
                if (r_req.operation == OP_INSERT
                    && (!i_rd_valid || i_rd_data.key == r_req.key)) begin
                    w_cmd.wr_en     = 1'b1;
                    w_cmd.set_valid = 1'b1;
                    w_cmd.wr_addr   = r_idx;
                    w_cmd.wr_data   = '{key: r_req.key, value: r_req.value, home: r_home};
                end else if (r_req.operation == OP_DELETE && i_rd_valid
                    && i_rd_data.key == r_req.key) begin
                    w_cmd.clr_valid = 1'b1;
                    w_cmd.clr_addr  = r_idx;
                end
            end
            S_DEL_RD: begin
                w_cmd.rd_en   = r_j < r_n;
                w_cmd.rd_addr = w_hole_inc[IdxW-1:0];
            end
            S_DEL_CHK: begin
                w_cmd.clr_valid = i_rd_valid;
                w_cmd.clr_addr  = r_hole;
            end
            S_RE_RD: begin
                w_cmd.rd_en   = 1'b1;
                w_cmd.rd_addr = r_ri;
            end
            S_RE_CHK: begin
                if (!i_rd_valid || i_rd_data.key == r_ent.key) begin
                    w_cmd.wr_en     = 1'b1;
                    w_cmd.set_valid = 1'b1;
                    w_cmd.wr_addr   = r_ri;
                    w_cmd.wr_data   = r_ent;
                end
            end
            default: w_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_req  <= n_req;
        r_n    <= n_n;
        r_home <= n_home;
        r_idx  <= n_idx;
        r_i    <= n_i;
        r_hole <= n_hole;
        r_j    <= n_j;
        r_ent  <= n_ent;
        r_k    <= n_k;
        r_ri   <= n_ri;
        r_rsp  <= n_rsp;
    end

    // divider shared between the hash and the re-placed home
    assign o_mod_start    = (r_state == S_IDLE && i_start)
                         || (r_state == S_DEL_CHK && i_rd_valid && w_home_far);
    assign o_mod_dividend = (r_state == S_IDLE) ? i_req.key_hash
                                                : {{(32-IdxW){1'b0}}, i_rd_data.home};

    assign o_busy      = r_state != S_IDLE;
    assign o_n         = w_n;
    assign o_cmd       = w_cmd;
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;

    `LPHT_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `LPHT_ASSERT_IMPL(a_no_dual_write, i_clk, i_rst_n, 1'b1, !(w_cmd.wr_en && w_cmd.rd_en))
    `LPHT_ASSERT_NEXT(a_strobe_idle, i_clk, i_rst_n, r_state == S_DONE, !o_busy && o_strobe)
    `LPHT_ASSERT_IMPL(a_probe_bound, i_clk, i_rst_n, o_busy, r_i < r_n || r_state == S_IDLE)
endmodule

@@ sv/linear_probe_hash_table_top.sv @@
// Open-addressing hash table with linear probing, up to 256 slots.
// Requests: drive i_req and raise start while busy is low; the request is
// taken at that edge and busy stays high until the answer is due.
// Each request gives one answer: o_rsp is valid for the single cycle in
// which o_strobe is high, the first cycle with busy low; the receiver
// cannot stall and must take it then.
// Sequence: the bit-serial divider forms the hash remainder, then each
// slot probed is read from memory and then compared and, if needed,
// written; a final step raises the answer. A delete then walks the
// following entries of the cluster, reading each and probing slots to
// re-place it, until an empty slot or the slot count ends the walk. A
// stored home beyond the slot count is first reduced by the divider. One
// request is handled at a time. Configuration: i_cfg_we with i_cfg_data
// sets the slot count; the user must write it only while idle, the block
// does not enforce it. Zero acts as one and values above 256 act as 256.
// Reset clears all valid bits and sets the slot count to 256.
module linear_probe_hash_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lpht_pkg::t_req    i_req,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_data,
    output logic              o_strobe,
    output lpht_pkg::t_rsp    o_rsp
);
    import lpht_pkg::*;

    logic [8:0]      r_slots;
    logic            w_mod_start;
    logic [31:0]     w_mod_dividend;
    logic [CntW-1:0] w_n;
    logic            w_mod_done;
    logic [CntW-1:0] w_mod_rem;
    t_mem_cmd        w_cmd;
    t_entry          w_rd_data;
    logic            w_rd_valid;

    // slot count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= 9'd256;
        end else if (i_cfg_we) begin
            r_slots <= i_cfg_data;
        end
    end

    lpht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dividend),
        .i_divisor  (w_n),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    lpht_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_rd_data  (w_rd_data),
        .o_rd_valid (w_rd_valid)
    );

    lpht_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_req          (i_req),
        .i_slots        (r_slots),
        .o_busy         (busy),
        .o_mod_start    (w_mod_start),
        .o_mod_dividend (w_mod_dividend),
        .o_n            (w_n),
        .i_mod_done     (w_mod_done),
        .i_mod_rem      (w_mod_rem),
        .o_cmd          (w_cmd),
        .i_rd_data      (w_rd_data),
        .i_rd_valid     (w_rd_valid),
        .o_strobe       (o_strobe),
        .o_rsp          (o_rsp)
    );
endmodule
